@@ sv/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg: shared types and constants for the date offset block
// Field widths, calendar constants, sequencer states and the month table.
// ----------------------------------------------------------------------------
package gdad_pkg;

	localparam int YEAR_W    = 14;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int CENT_W    = 8;
	localparam int YY_W      = 7;
	localparam int PROD_W    = 27;
	localparam int RECIP_SH  = 19;
	localparam int OFFSET_BITS_DEF = 11;
	localparam int OUT_DATA_W = ((YEAR_W + MONTH_W + DAY_W + 7) / 8) * 8;

	localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
	localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(0);
	localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(11);
	localparam logic [YY_W-1:0]    YY_LAST    = YY_W'(99);
	localparam logic [PROD_W-1:0]  RECIP_100  = PROD_W'(5243);
	localparam logic [14:0]        CENT_SCALE = 15'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CENT,
		ST_YRS,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  y;
		logic [CENT_W-1:0]  c;
		logic [YY_W-1:0]    yy;
		logic [MONTH_W-1:0] m;
	} cursor_t;

	typedef struct packed {
		logic more;
		logic ovf;
	} step_stat_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1:                 n = leap ? DAY_W'(29) : DAY_W'(28);
			4'd3, 4'd5, 4'd8, 4'd10: n = DAY_W'(30);
			default:              n = DAY_W'(31);
		endcase
		return n;
	endfunction

endpackage

@@ sv/gdad_month_step.sv @@
// ----------------------------------------------------------------------------
// gdad_month_step: one month of the date walk
// Carries or borrows one month's length into the day count and moves the
// month and year cursor by one month, flagging a year leaving its range.
// ----------------------------------------------------------------------------
module gdad_month_step import gdad_pkg::*; #(
	parameter int DW = 12
) (
	input  cursor_t              cur,
	input  logic signed [DW-1:0] d,
	input  logic                 fwd,
	output cursor_t              nxt,
	output logic signed [DW-1:0] d_nxt,
	output step_stat_t           stat
);

	logic                 leap;
	logic [MONTH_W-1:0]   mi;
	logic [DAY_W-1:0]     dim;
	logic signed [DW-1:0] dim_s;
	logic signed [DW-1:0] addend;

	assign leap   = (cur.yy[1:0] == 2'b00) && ((cur.yy != '0) || (cur.c[1:0] == 2'b00));
	assign mi     = fwd ? cur.m : ((cur.m == MONTH_JAN) ? MONTH_DEC : cur.m - MONTH_W'(1));
	assign dim    = month_days(mi, leap);
	assign dim_s  = $signed({{(DW-DAY_W){1'b0}}, dim});
	assign addend = fwd ? -dim_s : dim_s;
	assign d_nxt  = d + addend;

	always_comb begin
		nxt       = cur;
		stat.ovf  = 1'b0;
		if (fwd) begin
			stat.more = d > dim_s;
			if (cur.m == MONTH_DEC) begin
				nxt.m = MONTH_JAN;
				if (cur.y == YEAR_MAX) begin
					stat.ovf = 1'b1;
				end
				nxt.y = cur.y + YEAR_W'(1);
				if (cur.yy == YY_LAST) begin
					nxt.yy = '0;
					nxt.c  = cur.c + CENT_W'(1);
				end else begin
					nxt.yy = cur.yy + YY_W'(1);
				end
			end else begin
				nxt.m = cur.m + MONTH_W'(1);
			end
		end else begin
			stat.more = d[DW-1] || (d == '0);
			nxt.m     = mi;
			if (cur.m == MONTH_JAN) begin
				if (cur.y == '0) begin
					stat.ovf = 1'b1;
				end
				nxt.y = cur.y - YEAR_W'(1);
				if (cur.yy == '0) begin
					nxt.yy = YY_LAST;
					nxt.c  = cur.c - CENT_W'(1);
				end else begin
					nxt.yy = cur.yy - YY_W'(1);
				end
			end
		end
		stat.ovf = stat.ovf && stat.more;
	end

endmodule

@@ sv/gregorian_date_add_days.sv @@
// Sequence: the input beat passes the MUL, CENT and YRS states, then the WALK
// state crosses the months (up to about 35 at the default offset width); the
// month step unit handles one month per cycle. A year above range in the
// input skips the walk and answers in the cycle after it is taken.
// Throughput: one beat at a time; the next input is taken once the result
// has left. Reset returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
// gregorian_date_add_days: calendar date plus a signed day offset
// Splits the year into century and year of century, then walks month by
// month through a shared step unit until the day falls inside its month.
// ----------------------------------------------------------------------------
module gregorian_date_add_days import gdad_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	localparam int IN_DATA_W  = ((YEAR_W + MONTH_W + DAY_W + OFFSET_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// year, month, day_of_month, day_offset
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// new_year, new_month, new_day
	output logic [OUT_DATA_W-1:0] m_tdata,
	// year_overflow
	output logic                  m_tuser
);

	localparam int DW = ((OFFSET_BITS > 6) ? OFFSET_BITS : 6) + 1;

	logic [YEAR_W-1:0]             in_year;
	logic [MONTH_W-1:0]            in_month;
	logic [DAY_W-1:0]              in_day;
	logic signed [OFFSET_BITS-1:0] in_off;
	logic                          s_fire;
	logic                          in_ovf;

	state_t state_q, state_d;

	logic [YEAR_W-1:0]    yin_q;
	logic [MONTH_W-1:0]   min_q;
	logic [DAY_W-1:0]     din_q;
	cursor_t              cur_q;
	logic signed [DW-1:0] d_q;
	logic                 fwd_q;
	logic [PROD_W-1:0]    prod_q;

	cursor_t              nxt;
	logic signed [DW-1:0] d_nxt;
	step_stat_t           stat;

	logic [YEAR_W-1:0]  new_year_q;
	logic [MONTH_W-1:0] new_month_q;
	logic [DAY_W-1:0]   new_day_q;
	logic               ovf_q;

	assign in_year  = s_tdata[YEAR_W-1:0];
	assign in_month = s_tdata[YEAR_W +: MONTH_W];
	assign in_day   = s_tdata[YEAR_W+MONTH_W +: DAY_W];
	assign in_off   = $signed(s_tdata[YEAR_W+MONTH_W+DAY_W +: OFFSET_BITS]);
	assign s_fire   = s_tvalid && s_tready;
	assign in_ovf   = in_year > YEAR_MAX;

	gdad_month_step #(
		.DW(DW)
	) u_step (
		.cur   (cur_q),
		.d     (d_q),
		.fwd   (fwd_q),
		.nxt   (nxt),
		.d_nxt (d_nxt),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = in_ovf ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_CENT;
			ST_CENT: state_d = ST_YRS;
			ST_YRS:  state_d = ST_WALK;
			ST_WALK: begin
				if (stat.ovf || !stat.more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			yin_q    <= in_year;
			min_q    <= in_month;
			din_q    <= in_day;
			cur_q.y  <= in_year;
			cur_q.m  <= (in_month > MONTH_DEC) ? MONTH_DEC : in_month;
			d_q      <= $signed({{(DW-DAY_W){1'b0}}, in_day})
				+ DW'(in_off);
			fwd_q    <= !in_off[OFFSET_BITS-1] && (in_off != '0);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(cur_q.y) * RECIP_100;
		end
		if (state_q == ST_CENT) begin
			cur_q.c <= prod_q[PROD_W-1:RECIP_SH];
		end
		if (state_q == ST_YRS) begin
			cur_q.yy <= YY_W'(cur_q.y - YEAR_W'(15'(cur_q.c) * CENT_SCALE));
		end
		if ((state_q == ST_WALK) && stat.more && !stat.ovf) begin
			cur_q <= nxt;
			d_q   <= d_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && in_ovf) begin
			new_year_q  <= in_year;
			new_month_q <= in_month;
			new_day_q   <= in_day;
			ovf_q       <= 1'b1;
		end
		if (state_q == ST_WALK) begin
			if (stat.ovf) begin
				new_year_q  <= yin_q;
				new_month_q <= min_q;
				new_day_q   <= din_q;
				ovf_q       <= 1'b1;
			end else if (!stat.more) begin
				new_year_q  <= cur_q.y;
				new_month_q <= cur_q.m;
				new_day_q   <= d_q[DAY_W-1:0];
				ovf_q       <= 1'b0;
			end
		end
	end

	assign m_tdata = {{(OUT_DATA_W-YEAR_W-MONTH_W-DAY_W){1'b0}},
		new_day_q, new_month_q, new_year_q};
	assign m_tuser = ovf_q;

endmodule
